FILE: src/idksm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idksm_pkg: shared types and constants for the masked IDEA key schedule
// Schedule length, rotation amounts, mask reset value, sequencer states and
// the control bundle that drives the key rotator.
// ----------------------------------------------------------------------------
package idksm_pkg;

  localparam int NumSubkeys = 52;
  localparam int KeyWidth   = 128;
  localparam int WordWidth  = 16;
  localparam int IdxWidth   = 6;
  localparam int GroupRot   = 25;

  localparam logic [WordWidth-1:0] MaskReset = 16'h0dae;
  localparam logic [IdxWidth-1:0]  LastIdx   = IdxWidth'(NumSubkeys - 1);
  localparam logic [2:0]           GroupEnd  = 3'd7;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;       // capture a new key
    logic step;       // advance to the next subkey
    logic group_end;  // step crosses into the next group of eight
  } rot_ctl_t;

endpackage

FILE: src/idksm_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idksm_rotator: rotating 128-bit key register
// Presents the current subkey word at the top 16 bits. A step rotates left by
// one word; at the end of a group it also applies the 25-bit group rotation.
// ----------------------------------------------------------------------------
module idksm_rotator (
  input  logic                             clk,
  input  idksm_pkg::rot_ctl_t              ctl,
  input  logic [idksm_pkg::KeyWidth-1:0]   key_in,
  output logic [idksm_pkg::WordWidth-1:0]  word
);

  localparam int RotWord  = idksm_pkg::WordWidth;
  localparam int RotGroup = idksm_pkg::WordWidth + idksm_pkg::GroupRot;

  logic [idksm_pkg::KeyWidth-1:0] key_r;
  logic [idksm_pkg::KeyWidth-1:0] key_nxt;
  logic [idksm_pkg::KeyWidth-1:0] rot_word;
  logic [idksm_pkg::KeyWidth-1:0] rot_group;

  assign rot_word  = {key_r[idksm_pkg::KeyWidth-RotWord-1:0],
                      key_r[idksm_pkg::KeyWidth-1:idksm_pkg::KeyWidth-RotWord]};
  assign rot_group = {key_r[idksm_pkg::KeyWidth-RotGroup-1:0],
                      key_r[idksm_pkg::KeyWidth-1:idksm_pkg::KeyWidth-RotGroup]};

  always_comb begin
    key_nxt = key_r;
    if (ctl.load) begin
      key_nxt = key_in;
    end else if (ctl.step) begin
      key_nxt = ctl.group_end ? rot_group : rot_word;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign word = key_r[idksm_pkg::KeyWidth-1:idksm_pkg::KeyWidth-idksm_pkg::WordWidth];

endmodule

FILE: src/idea_key_schedule_masked_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idea_key_schedule_masked_top: masked IDEA encryption key schedule
// Usage:
//   Input channel (in_valid / in_stall) takes one 128-bit user key as two
//   64-bit halves. The block then emits the 52 encryption subkeys on the
//   output channel (out_valid / out_stall), one beat each, with the index
//   and a last flag on subkey 51. Each subkey is XORed with the mask.
//   A taken key beat is first loaded into the rotating key register; the
//   first subkey is then registered in the output register. After that one
//   subkey per cycle while out_stall is low, set by the single rotating key
//   register that yields one word per cycle. Keys are handled one at a time:
//   the 52 subkeys are emitted, then the next key is loaded while idle.
//   in_stall stays high from the key beat until subkey 51 is loaded into
//   the output register; the next key may be taken while that beat waits.
//   A stalled output holds its beat and pauses the sequencer.
//   Config channel (cfg_valid / cfg_ready) writes the 16-bit mask; it is
//   always ready. The user must write it only while the block is idle; the block itself does not enforce this.
//   Reset (rst_n low, synchronous) returns to idle, drops any pending
//   output and sets the mask to 0x0dae.
// ----------------------------------------------------------------------------
module idea_key_schedule_masked_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [63:0]                       in_key_hi,
  input  logic [63:0]                       in_key_lo,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [idksm_pkg::WordWidth-1:0]   out_subkey,
  output logic [idksm_pkg::IdxWidth-1:0]    out_subkey_index,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [idksm_pkg::WordWidth-1:0]   cfg_subkey_mask
);

  idksm_pkg::state_t state_r, state_nxt;
  logic [idksm_pkg::IdxWidth-1:0]  idx_r, idx_nxt;
  logic [idksm_pkg::WordWidth-1:0] mask_r, mask_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [idksm_pkg::WordWidth-1:0] subkey_r, subkey_nxt;
  logic [idksm_pkg::IdxWidth-1:0]  oidx_r, oidx_nxt;
  logic                            last_r, last_nxt;

  idksm_pkg::rot_ctl_t             ctl;
  logic [idksm_pkg::WordWidth-1:0] word;
  logic                            slot_free;

  idksm_rotator u_rot (
    .clk    (clk),
    .ctl    (ctl),
    .key_in ({in_key_hi, in_key_lo}),
    .word   (word)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    subkey_nxt    = subkey_r;
    oidx_nxt      = oidx_r;
    last_nxt      = last_r;
    ctl           = '0;
    in_stall      = 1'b1;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      mask_nxt = cfg_subkey_mask;
    end

    case (state_r)
      idksm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = idksm_pkg::ST_RUN;
        end
      end
      idksm_pkg::ST_RUN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          subkey_nxt    = word ^ mask_r;
          oidx_nxt      = idx_r;
          last_nxt      = (idx_r == idksm_pkg::LastIdx);
          ctl.step      = 1'b1;
          ctl.group_end = (idx_r[2:0] == idksm_pkg::GroupEnd);
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == idksm_pkg::LastIdx) begin
            state_nxt = idksm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = idksm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idksm_pkg::ST_IDLE;
      idx_r       <= '0;
      mask_r      <= idksm_pkg::MaskReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    subkey_r <= subkey_nxt;
    oidx_r   <= oidx_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_subkey       = subkey_r;
  assign out_subkey_index = oidx_r;
  assign out_last         = last_r;

endmodule
